>>> hw/rtl/scdb_pkg.sv
// shared types, constants and calendar helpers for the day-span block
`default_nettype none

package scdb_pkg;

	localparam int DAY_W         = 5;
	localparam int MON_W         = 4;
	localparam int SPAN_W        = 21;
	localparam int YEAR_BITS_DEF = 12;
	localparam int YEAR_CALC_W   = 16;
	localparam int RES_W         = 6;
	localparam int CYCLE_LEN     = 33;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [MON_W-1:0] MONTH_LAST = MON_W'(12);
	localparam logic [SPAN_W-1:0] SPAN_MAX  = {SPAN_W{1'b1}};

	// residues of the 33-year cycle that are leap years
	localparam logic [CYCLE_LEN-1:0] LEAP_SET =
		(CYCLE_LEN'(1) << 1) | (CYCLE_LEN'(1) << 5) | (CYCLE_LEN'(1) << 9) |
		(CYCLE_LEN'(1) << 13) | (CYCLE_LEN'(1) << 17) | (CYCLE_LEN'(1) << 22) |
		(CYCLE_LEN'(1) << 26) | (CYCLE_LEN'(1) << 30);

	typedef enum logic {
		BK_IDLE,
		BK_WALK
	} back_state_t;

	// 2^5 = -1 mod 33, so fold 5-bit chunks with alternating sign
	function automatic logic [RES_W-1:0] mod33(input logic [YEAR_CALC_W-1:0] y);
		logic [6:0] pos;
		logic [5:0] neg;
		logic [7:0] r;
		pos = 7'(y[4:0]) + 7'(y[14:10]);
		neg = 6'(y[9:5]) + 6'(y[15]);
		r   = 8'(pos) + 8'(2 * CYCLE_LEN) - 8'(neg);
		for (int i = 0; i < 3; i++) begin
			if (r >= 8'(CYCLE_LEN))
				r = r - 8'(CYCLE_LEN);
		end
		return r[RES_W-1:0];
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			[MON_W'(1):MON_W'(6)]:  len = DAY_W'(31);
			[MON_W'(7):MON_W'(11)]: len = DAY_W'(30);
			MONTH_LAST:             len = leap ? DAY_W'(30) : DAY_W'(29);
			default:                len = '0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/solar_calendar_days_between.sv
// top level of the solar calendar day-span block
`default_nettype none

// Takes two Solar Hijri dates and returns the absolute number of days between
// them, whether the first date was the later one, and a flag for an invalid
// date (then the span is 0). The front end checks and orders each item in the
// cycle it is accepted and places it in a two-entry queue; the back end walks
// the earlier date forward one day per clock until it meets the later date.
// An item is therefore loaded into the walker, stepped forward once for each
// day of the span and then, once the match is seen and the output register
// is free, has its result registered. Up to two further items are taken
// while the walker is busy; req_stall rises when the queue is full. The
// result waits in an output register until taken.
module solar_calendar_days_between #(
	parameter int YEAR_BITS = scdb_pkg::YEAR_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire logic [scdb_pkg::DAY_W-1:0]  first_day,
	input  wire logic [scdb_pkg::MON_W-1:0]  first_month,
	input  wire logic [YEAR_BITS-1:0]        first_year,
	input  wire logic [scdb_pkg::DAY_W-1:0]  second_day,
	input  wire logic [scdb_pkg::MON_W-1:0]  second_month,
	input  wire logic [YEAR_BITS-1:0]        second_year,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output logic [scdb_pkg::SPAN_W-1:0]      day_span,
	output logic                             first_is_later,
	output logic                             bad_date
);
	import scdb_pkg::*;

	localparam int JOB_W = 2 + RES_W + 2 * (YEAR_BITS + DAY_W + MON_W);

	logic             push, full, pop, avail;
	logic [JOB_W-1:0] push_job, head_job;

	assign req_stall = full;

	scdb_front #(
		.YEAR_BITS(YEAR_BITS)
	) u_front (
		.valid        (req_valid),
		.first_day    (first_day),
		.first_month  (first_month),
		.first_year   (first_year),
		.second_day   (second_day),
		.second_month (second_month),
		.second_year  (second_year),
		.full         (full),
		.push         (push),
		.job          (push_job)
	);

	scdb_queue #(
		.DATA_W (JOB_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (full),
		.pop       (pop),
		.avail     (avail),
		.head      (head_job)
	);

	scdb_back #(
		.YEAR_BITS(YEAR_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.avail          (avail),
		.job            (head_job),
		.pop            (pop),
		.valid          (rsp_valid),
		.stall          (rsp_stall),
		.day_span       (day_span),
		.first_is_later (first_is_later),
		.bad_date       (bad_date)
	);

endmodule

`default_nettype wire

>>> hw/rtl/scdb_front.sv
// front end: checks both dates, orders them and builds a walk job
`default_nettype none

module scdb_front #(
	parameter int YEAR_BITS = scdb_pkg::YEAR_BITS_DEF
) (
	input  wire logic                        valid,
	input  wire logic [scdb_pkg::DAY_W-1:0]  first_day,
	input  wire logic [scdb_pkg::MON_W-1:0]  first_month,
	input  wire logic [YEAR_BITS-1:0]        first_year,
	input  wire logic [scdb_pkg::DAY_W-1:0]  second_day,
	input  wire logic [scdb_pkg::MON_W-1:0]  second_month,
	input  wire logic [YEAR_BITS-1:0]        second_year,
	input  wire logic                        full,
	output logic                             push,
	output logic [2+scdb_pkg::RES_W+2*(YEAR_BITS+scdb_pkg::DAY_W+scdb_pkg::MON_W)-1:0] job
);
	import scdb_pkg::*;

	logic [RES_W-1:0] res1, res2;
	logic [DAY_W-1:0] len1, len2;
	logic             ok1, ok2, later;

	assign res1 = mod33(YEAR_CALC_W'(first_year));
	assign res2 = mod33(YEAR_CALC_W'(second_year));
	assign len1 = month_len(first_month, LEAP_SET[res1]);
	assign len2 = month_len(second_month, LEAP_SET[res2]);
	assign ok1  = (len1 != '0) && (first_day != '0) && (first_day <= len1);
	assign ok2  = (len2 != '0) && (second_day != '0) && (second_day <= len2);

	// valid dates order lexicographically by year, month, day
	assign later = {first_year, first_month, first_day} >
		{second_year, second_month, second_day};

	assign push = valid && !full;

	always_comb begin
		if (!(ok1 && ok2)) begin
			// walk from zero to zero: count stays 0
			job = '0;
			job[$bits(job)-1] = 1'b1;
		end else if (later) begin
			job = {1'b0, 1'b1, res2, second_year, second_month, second_day,
				first_year, first_month, first_day};
		end else begin
			job = {1'b0, 1'b0, res1, first_year, first_month, first_day,
				second_year, second_month, second_day};
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/scdb_queue.sv
// small fifo between the front end and the day walker
`default_nettype none

module scdb_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = scdb_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   avail,
	output logic [DATA_W-1:0]      head
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign avail = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/scdb_back.sv
// back end: walks the earlier date forward one day a cycle to the later one
`default_nettype none

module scdb_back #(
	parameter int YEAR_BITS = scdb_pkg::YEAR_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         avail,
	input  wire logic [2+scdb_pkg::RES_W+2*(YEAR_BITS+scdb_pkg::DAY_W+scdb_pkg::MON_W)-1:0] job,
	output logic                              pop,
	output logic                              valid,
	input  wire logic                         stall,
	output logic [scdb_pkg::SPAN_W-1:0]       day_span,
	output logic                              first_is_later,
	output logic                              bad_date
);
	import scdb_pkg::*;

	logic             j_bad, j_later;
	logic [RES_W-1:0] j_res;
	logic [YEAR_BITS-1:0] j_wy, j_gy;
	logic [MON_W-1:0] j_wm, j_gm;
	logic [DAY_W-1:0] j_wd, j_gd;

	back_state_t state_q, state_d;

	logic [DAY_W-1:0]     walk_day_q, goal_day_q;
	logic [MON_W-1:0]     walk_month_q, goal_month_q;
	logic [YEAR_BITS-1:0] walk_year_q, goal_year_q;
	logic [RES_W-1:0]     walk_res_q;
	logic [SPAN_W-1:0]    span_count_q;
	logic                 later_q, bad_q;

	logic [SPAN_W-1:0] span_q;
	logic              out_later_q, out_bad_q, out_valid_q;

	logic             at_goal, out_free, load_out, step;
	logic [DAY_W-1:0] mlen;

	assign {j_bad, j_later, j_res, j_wy, j_wm, j_wd, j_gy, j_gm, j_gd} = job;

	assign at_goal  = (walk_day_q == goal_day_q) && (walk_month_q == goal_month_q) &&
		(walk_year_q == goal_year_q);
	assign out_free = !out_valid_q || !stall;
	assign mlen     = month_len(walk_month_q, LEAP_SET[walk_res_q]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (avail)
					state_d = BK_WALK;
			end
			BK_WALK: begin
				if (at_goal && out_free)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		step     = 1'b0;
		case (state_q)
			BK_IDLE: pop = avail;
			BK_WALK: begin
				load_out = at_goal && out_free;
				step     = !at_goal;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			walk_day_q   <= j_wd;
			walk_month_q <= j_wm;
			walk_year_q  <= j_wy;
			walk_res_q   <= j_res;
			goal_day_q   <= j_gd;
			goal_month_q <= j_gm;
			goal_year_q  <= j_gy;
			later_q      <= j_later;
			bad_q        <= j_bad;
			span_count_q <= '0;
		end else if (step) begin
			if (span_count_q != SPAN_MAX)
				span_count_q <= span_count_q + 1'b1;
			if (walk_day_q < mlen) begin
				walk_day_q <= walk_day_q + 1'b1;
			end else begin
				walk_day_q <= DAY_W'(1);
				if (walk_month_q < MONTH_LAST) begin
					walk_month_q <= walk_month_q + 1'b1;
				end else begin
					walk_month_q <= MON_W'(1);
					walk_year_q  <= walk_year_q + 1'b1;
					walk_res_q   <= (walk_res_q == RES_W'(CYCLE_LEN - 1)) ? '0 :
						walk_res_q + 1'b1;
				end
			end
		end
		if (load_out) begin
			span_q      <= span_count_q;
			out_later_q <= later_q;
			out_bad_q   <= bad_q;
		end
	end

	assign valid          = out_valid_q;
	assign day_span       = span_q;
	assign first_is_later = out_later_q;
	assign bad_date       = out_bad_q;

endmodule

`default_nettype wire
